// File: rtl/lfc_pkg.sv
// Package for the line follower turn controller: codes, register layout and reset values.
package lfc_pkg;

	localparam int TIME_BITS_DEF = 32;

	localparam int PWM_W  = 14;
	localparam int DUR_W  = 16;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 16;
	localparam int SENS_W = 8;

	localparam logic [SENS_W-1:0] CENTRE_BITS = 8'b0001_1000;
	localparam logic [SENS_W-1:0] LEFT_BITS   = 8'b1110_0000;
	localparam logic [SENS_W-1:0] RIGHT_BITS  = 8'b0000_0111;
	localparam int INNER_RIGHT_BIT = 3;
	localparam int INNER_LEFT_BIT  = 4;

	localparam logic [PWM_W-1:0] PWM_RESET      = 14'd2500;
	localparam logic [DUR_W-1:0] SIDE_RESET     = 16'd1050;
	localparam logic [DUR_W-1:0] UTURN_RESET    = 16'd2500;
	localparam logic [DUR_W-1:0] WHITE_RESET    = 16'd300;
	localparam logic [DUR_W-1:0] JUNCTION_RESET = 16'd50;

	// floor(x/3) == (x*THIRD_MUL) >> THIRD_SHIFT for every x below 2^17
	localparam int THIRD_MUL   = 43691;
	localparam int THIRD_SHIFT = 17;

	typedef enum logic [1:0] {
		TURN_NONE  = 2'd0,
		TURN_LEFT  = 2'd1,
		TURN_RIGHT = 2'd2,
		TURN_BACK  = 2'd3
	} turn_t;

	typedef enum logic [1:0] {
		MODE_FWD    = 2'd0,
		MODE_SPIN_L = 2'd1,
		MODE_SPIN_R = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		LAMP_OFF     = 3'd0,
		LAMP_RED     = 3'd1,
		LAMP_GREEN   = 3'd2,
		LAMP_YELLOW  = 3'd3,
		LAMP_BLUE    = 3'd4,
		LAMP_MAGENTA = 3'd5,
		LAMP_CYAN    = 3'd6
	} led_t;

	typedef enum logic [IDX_W-1:0] {
		REG_PWM_NOMINAL  = 3'd0,
		REG_SIDE_TURN    = 3'd1,
		REG_UTURN        = 3'd2,
		REG_WHITE_TIME   = 3'd3,
		REG_JUNCTION     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [PWM_W-1:0] pwm;
		logic [PWM_W-1:0] pwm_third;
		logic [PWM_W-1:0] pwm_half;
		logic [DUR_W-1:0] side_ms;
		logic [DUR_W-1:0] uturn_ms;
		logic [DUR_W-1:0] white_ms;
		logic [DUR_W-1:0] junction_ms;
	} cfg_t;

endpackage

// File: rtl/lfc_if.sv
// Channel interfaces for sensor items, motor results and register writes.
interface lfc_in_if
	import lfc_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [SENS_W-1:0] sensor_bits;
	modport source (output valid, kind, sensor_bits, input ready);
	modport sink (input valid, kind, sensor_bits, output ready);
endinterface

interface lfc_out_if
	import lfc_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic             motor_update;
	logic [1:0]       motor_mode;
	logic [PWM_W-1:0] left_duty;
	logic [PWM_W-1:0] right_duty;
	logic [2:0]       led_colour;
	modport source (output valid, motor_update, motor_mode, left_duty, right_duty, led_colour,
		input ready);
	modport sink (input valid, motor_update, motor_mode, left_duty, right_duty, led_colour,
		output ready);
endinterface

interface lfc_cfg_if
	import lfc_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/lfc_cfg_regs.sv
// Configuration register file with the derived third and half duties.
module lfc_cfg_regs
	import lfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	lfc_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t             regs_q;
	logic [PWM_W-1:0] pwm_new;
	logic [31:0]      third_prod;

	assign cfg.ready  = 1'b1;
	assign pwm_new    = cfg.data[PWM_W-1:0];
	assign third_prod = 32'(pwm_new) * 32'(THIRD_MUL);
	assign regs       = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pwm         <= PWM_RESET;
			regs_q.pwm_third   <= PWM_W'(PWM_RESET / 3);
			regs_q.pwm_half    <= PWM_W'(PWM_RESET / 2);
			regs_q.side_ms     <= SIDE_RESET;
			regs_q.uturn_ms    <= UTURN_RESET;
			regs_q.white_ms    <= WHITE_RESET;
			regs_q.junction_ms <= JUNCTION_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PWM_NOMINAL: begin
					regs_q.pwm       <= pwm_new;
					regs_q.pwm_third <= PWM_W'(third_prod >> THIRD_SHIFT);
					regs_q.pwm_half  <= pwm_new >> 1;
				end
				REG_SIDE_TURN:  regs_q.side_ms     <= cfg.data[DUR_W-1:0];
				REG_UTURN:      regs_q.uturn_ms    <= cfg.data[DUR_W-1:0];
				REG_WHITE_TIME: regs_q.white_ms    <= cfg.data[DUR_W-1:0];
				REG_JUNCTION:   regs_q.junction_ms <= cfg.data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/line_follower_turn_controller.sv
// Top level of the line follower turn controller.
//
//  channel | dir | payload                                          | beat
//  item    | in  | kind, sensor_bits                                | valid && ready
//  result  | out | motor_update, motor_mode, left/right_duty, led  | valid && ready
//  cfg     | in  | index, data                                      | valid && ready
//
// One item a cycle while no sample waits on a stalled result; an item lands in the input
// register, is decided there, and a sample's result lands in the result register.
// A tick gives no result and only advances the millisecond clock.
// A stalled result holds the sample behind it and the items after it; ticks ahead of it still flow.
// Reset clears all timing state and restores the register defaults; cfg is always ready.
module line_follower_turn_controller
	import lfc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lfc_in_if.sink    item,
	lfc_out_if.source result,
	lfc_cfg_if.sink   cfg
);

	cfg_t regs;

	lfc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	logic              valid_s1;
	logic              kind_s1;
	logic [SENS_W-1:0] bits_s1;
	logic              adv_s1;
	logic              sample_adv;

	logic [TIME_BITS-1:0] clock_q, turn_start_q, white_start_q, junc_start_q;
	turn_t                turn_q;
	logic                 white_seen_q, junc_seen_q;

	logic [TIME_BITS-1:0] clock_n, turn_start_n, white_start_n, junc_start_n;
	turn_t                turn_n;
	logic                 white_seen_n, junc_seen_n;

	logic [TIME_BITS-1:0] turn_el, white_el, junc_el, turn_dur;
	logic                 turn_hold, blank_row, white_fire;
	logic                 centre_full, left_full, right_full, junction, junc_fire;

	logic             upd_n;
	mode_t            mode_n;
	logic [PWM_W-1:0] ldut_n, rdut_n;
	led_t             led_n;

	logic             out_valid_q, upd_q;
	mode_t            mode_q;
	logic [PWM_W-1:0] ldut_q, rdut_q;
	led_t             led_q;

	assign sample_adv = valid_s1 && kind_s1 && (!out_valid_q || result.ready);
	assign adv_s1     = valid_s1 && (!kind_s1 || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1 <= item.kind;
			bits_s1 <= item.sensor_bits;
		end
	end

	assign turn_dur    = (turn_q == TURN_BACK) ? TIME_BITS'(regs.uturn_ms)
		: TIME_BITS'(regs.side_ms);
	assign turn_el     = clock_q - turn_start_q;
	assign turn_hold   = (turn_q != TURN_NONE) && (turn_el < turn_dur);
	assign blank_row   = (bits_s1 == '0);
	assign white_el    = clock_q - (white_seen_q ? white_start_q : clock_q);
	assign white_fire  = blank_row && (white_el > TIME_BITS'(regs.white_ms));
	assign centre_full = (bits_s1 & CENTRE_BITS) == CENTRE_BITS;
	assign left_full   = (bits_s1 & LEFT_BITS) == LEFT_BITS;
	assign right_full  = (bits_s1 & RIGHT_BITS) == RIGHT_BITS;
	assign junction    = centre_full && (left_full || right_full);
	assign junc_el     = clock_q - (junc_seen_q ? junc_start_q : clock_q);
	assign junc_fire   = junction && (junc_el > TIME_BITS'(regs.junction_ms));

	always_comb begin
		clock_n       = clock_q;
		turn_n        = turn_q;
		turn_start_n  = turn_start_q;
		white_seen_n  = white_seen_q;
		white_start_n = white_start_q;
		junc_seen_n   = junc_seen_q;
		junc_start_n  = junc_start_q;
		upd_n         = 1'b1;
		mode_n        = MODE_FWD;
		ldut_n        = regs.pwm;
		rdut_n        = regs.pwm;
		led_n         = LAMP_GREEN;
		if (!kind_s1) begin
			clock_n = clock_q + 1'b1;
		end else if (turn_hold) begin
			case (turn_q)
				TURN_LEFT: begin
					mode_n = MODE_SPIN_L;
					led_n  = LAMP_BLUE;
				end
				TURN_RIGHT: begin
					mode_n = MODE_SPIN_R;
					led_n  = LAMP_RED;
				end
				default: begin
					mode_n = MODE_SPIN_L;
					led_n  = LAMP_MAGENTA;
				end
			endcase
		end else begin
			turn_n = TURN_NONE;
			if (blank_row) begin
				white_seen_n = 1'b1;
				if (!white_seen_q) begin
					white_start_n = clock_q;
				end
			end else begin
				white_seen_n = 1'b0;
			end
			if (white_fire) begin
				turn_n       = TURN_BACK;
				turn_start_n = clock_q;
				upd_n        = 1'b0;
				ldut_n       = '0;
				rdut_n       = '0;
				led_n        = LAMP_CYAN;
			end else begin
				if (junction) begin
					junc_seen_n = 1'b1;
					if (!junc_seen_q) begin
						junc_start_n = clock_q;
					end
				end else begin
					junc_seen_n = 1'b0;
				end
				if (junc_fire) begin
					turn_n       = left_full ? TURN_LEFT : TURN_RIGHT;
					turn_start_n = clock_q;
					junc_seen_n  = 1'b0;
					upd_n        = 1'b0;
					ldut_n       = '0;
					rdut_n       = '0;
					led_n        = junc_seen_q ? LAMP_OFF : LAMP_YELLOW;
				end else if (centre_full) begin
					ldut_n = regs.pwm;
				end else if (bits_s1[INNER_RIGHT_BIT]) begin
					rdut_n = regs.pwm_third;
				end else if (bits_s1[INNER_LEFT_BIT]) begin
					ldut_n = regs.pwm_third;
				end else begin
					ldut_n = regs.pwm_half;
					rdut_n = regs.pwm_half;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q       <= '0;
			turn_q        <= TURN_NONE;
			turn_start_q  <= '0;
			white_seen_q  <= 1'b0;
			white_start_q <= '0;
			junc_seen_q   <= 1'b0;
			junc_start_q  <= '0;
		end else if (adv_s1) begin
			clock_q       <= clock_n;
			turn_q        <= turn_n;
			turn_start_q  <= turn_start_n;
			white_seen_q  <= white_seen_n;
			white_start_q <= white_start_n;
			junc_seen_q   <= junc_seen_n;
			junc_start_q  <= junc_start_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sample_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_adv) begin
			upd_q  <= upd_n;
			mode_q <= mode_n;
			ldut_q <= ldut_n;
			rdut_q <= rdut_n;
			led_q  <= led_n;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.motor_update = upd_q;
	assign result.motor_mode   = mode_q;
	assign result.left_duty    = ldut_q;
	assign result.right_duty   = rdut_q;
	assign result.led_colour   = led_q;

endmodule

// File: rtl/lfc_checker.sv
// Port checker for the line follower turn controller, bound to the top level.
module lfc_checker
	import lfc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             valid,
	input logic             ready,
	input logic             update,
	input logic [1:0]       mode,
	input logic [PWM_W-1:0] ldut,
	input logic [PWM_W-1:0] rdut,
	input logic [2:0]       led
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable({update, mode, ldut, rdut, led}))
		else $error("stalled result beat changed");

	a_turn_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !update |-> mode == MODE_FWD && ldut == '0 && rdut == '0
			&& (led == LAMP_OFF || led == LAMP_CYAN))
		else $error("turn start beat carries a motor command");

	a_spin_colour: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (led == LAMP_BLUE || led == LAMP_MAGENTA || led == LAMP_RED) |->
			update && ldut == rdut
			&& (led == LAMP_RED ? mode == MODE_SPIN_R : mode == MODE_SPIN_L))
		else $error("spin beat with wrong mode or duties");

	a_forward_colour: assert property (@(posedge clk) disable iff (!arst_n)
		valid && update && mode == MODE_FWD |-> led == LAMP_GREEN)
		else $error("forward beat without green");

endmodule

bind line_follower_turn_controller lfc_checker u_lfc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.valid  (result.valid),
	.ready  (result.ready),
	.update (result.motor_update),
	.mode   (result.motor_mode),
	.ldut   (result.left_duty),
	.rdut   (result.right_duty),
	.led    (result.led_colour)
);

// File: test/tb.sv
// Testbench for the line follower turn controller: directed and random beats against a predictor.
module tb
	import lfc_pkg::*;
	();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_TICK     = 1'b0;
	localparam logic KIND_SAMPLE   = 1'b1;
	localparam int   SETTLE_CYCLES = 4;
	localparam int   QUIET_LIMIT   = 2000;
	localparam int   CHUNK_ITEMS   = 275;

	typedef struct {
		logic             upd;
		mode_t            mode;
		logic [PWM_W-1:0] l_duty;
		logic [PWM_W-1:0] r_duty;
		led_t             led;
	} motor_cmd_t;

	typedef enum {
		ROAD_WHITE,
		ROAD_CENTRE,
		ROAD_DRIFT_R,
		ROAD_DRIFT_L,
		ROAD_CROSS_L,
		ROAD_CROSS_R,
		ROAD_NOISE
	} road_t;

	logic clk = 1'b0;
	logic arst_n;

	lfc_in_if  item_ch ();
	lfc_out_if res_ch ();
	lfc_cfg_if cfg_ch ();

	line_follower_turn_controller #(.TIME_BITS(TIME_BITS_DEF)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [PWM_W-1:0]         duty_nom    = PWM_RESET;
	logic [DUR_W-1:0]         side_len    = SIDE_RESET;
	logic [DUR_W-1:0]         back_len    = UTURN_RESET;
	logic [DUR_W-1:0]         blank_limit = WHITE_RESET;
	logic [DUR_W-1:0]         cross_limit = JUNCTION_RESET;
	logic [TIME_BITS_DEF-1:0] ms_now      = '0;
	logic [TIME_BITS_DEF-1:0] spin_t0     = '0;
	logic [TIME_BITS_DEF-1:0] blank_t0    = '0;
	logic [TIME_BITS_DEF-1:0] cross_t0    = '0;
	turn_t                    spin_kind   = TURN_NONE;
	logic                     blank_on    = 1'b0;
	logic                     cross_on    = 1'b0;

	motor_cmd_t motor_q[$];
	int         mismatch_count  = 0;
	int         quiet_cycles    = 0;
	int         feed_gap_pct    = 0;
	int         drain_stall_pct = 0;

	function automatic void expect_cmd(input logic upd, input mode_t mode,
		input logic [PWM_W-1:0] l_duty, input logic [PWM_W-1:0] r_duty, input led_t led);
		motor_cmd_t cmd;
		cmd.upd = upd;
		cmd.mode = mode;
		cmd.l_duty = l_duty;
		cmd.r_duty = r_duty;
		cmd.led = led;
		motor_q.push_back(cmd);
	endfunction

	function automatic void decide_motor(input logic [SENS_W-1:0] d);
		logic [TIME_BITS_DEF-1:0] el;
		led_t led;
		logic c_full, l_full, r_full;
		led = LAMP_OFF;
		if (spin_kind != TURN_NONE) begin
			el = ms_now - spin_t0;
			if (spin_kind == TURN_LEFT && el < side_len) begin
				expect_cmd(1'b1, MODE_SPIN_L, duty_nom, duty_nom, LAMP_BLUE);
				return;
			end
			if (spin_kind == TURN_RIGHT && el < side_len) begin
				expect_cmd(1'b1, MODE_SPIN_R, duty_nom, duty_nom, LAMP_RED);
				return;
			end
			if (spin_kind == TURN_BACK && el < back_len) begin
				expect_cmd(1'b1, MODE_SPIN_L, duty_nom, duty_nom, LAMP_MAGENTA);
				return;
			end
			spin_kind = TURN_NONE;
		end
		if (d == '0) begin
			if (!blank_on) begin
				blank_on = 1'b1;
				blank_t0 = ms_now;
			end
			el = ms_now - blank_t0;
			if (el > blank_limit) begin
				spin_kind = TURN_BACK;
				spin_t0 = ms_now;
				expect_cmd(1'b0, MODE_FWD, '0, '0, LAMP_CYAN);
				return;
			end
		end else begin
			blank_on = 1'b0;
		end
		c_full = (d & CENTRE_BITS) == CENTRE_BITS;
		l_full = (d & LEFT_BITS) == LEFT_BITS;
		r_full = (d & RIGHT_BITS) == RIGHT_BITS;
		if (c_full && (l_full || r_full)) begin
			if (!cross_on) begin
				cross_on = 1'b1;
				cross_t0 = ms_now;
				led = LAMP_YELLOW;
			end
			el = ms_now - cross_t0;
			if (el > cross_limit) begin
				if (l_full)
					spin_kind = TURN_LEFT;
				else
					spin_kind = TURN_RIGHT;
				spin_t0 = ms_now;
				cross_on = 1'b0;
				expect_cmd(1'b0, MODE_FWD, '0, '0, led);
				return;
			end
		end else begin
			cross_on = 1'b0;
		end
		if (c_full)
			expect_cmd(1'b1, MODE_FWD, duty_nom, duty_nom, LAMP_GREEN);
		else if (d[INNER_RIGHT_BIT])
			expect_cmd(1'b1, MODE_FWD, duty_nom, PWM_W'(duty_nom / 3), LAMP_GREEN);
		else if (d[INNER_LEFT_BIT])
			expect_cmd(1'b1, MODE_FWD, PWM_W'(duty_nom / 3), duty_nom, LAMP_GREEN);
		else
			expect_cmd(1'b1, MODE_FWD, PWM_W'(duty_nom / 2), PWM_W'(duty_nom / 2),
				LAMP_GREEN);
	endfunction

	always @(posedge clk) begin : monitor
		motor_cmd_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (motor_q.size() == 0) begin
				$error("result beat with no command pending");
				mismatch_count++;
			end else begin
				want = motor_q.pop_front();
				if (res_ch.motor_update !== want.upd) begin
					$error("motor_update: expected %0d, got %0d", want.upd, res_ch.motor_update);
					mismatch_count++;
				end
				if (res_ch.motor_mode !== want.mode) begin
					$error("motor_mode: expected %0d, got %0d", want.mode, res_ch.motor_mode);
					mismatch_count++;
				end
				if (res_ch.left_duty !== want.l_duty) begin
					$error("left_duty: expected %0d, got %0d", want.l_duty, res_ch.left_duty);
					mismatch_count++;
				end
				if (res_ch.right_duty !== want.r_duty) begin
					$error("right_duty: expected %0d, got %0d", want.r_duty, res_ch.right_duty);
					mismatch_count++;
				end
				if (res_ch.led_colour !== want.led) begin
					$error("led_colour: expected %0d, got %0d", want.led, res_ch.led_colour);
					mismatch_count++;
				end
			end
		end
		if (item_ch.valid && item_ch.ready) begin
			if (item_ch.kind == KIND_SAMPLE)
				decide_motor(item_ch.sensor_bits);
			else
				ms_now++;
		end
		if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				REG_PWM_NOMINAL: duty_nom = cfg_ch.data[PWM_W-1:0];
				REG_SIDE_TURN:   side_len = cfg_ch.data[DUR_W-1:0];
				REG_UTURN:       back_len = cfg_ch.data[DUR_W-1:0];
				REG_WHITE_TIME:  blank_limit = cfg_ch.data[DUR_W-1:0];
				REG_JUNCTION:    cross_limit = cfg_ch.data[DUR_W-1:0];
				default: ;
			endcase
		end
		if ((res_ch.valid && res_ch.ready) || (item_ch.valid && item_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= drain_stall_pct);
	end

	task automatic send_item(input logic k, input logic [SENS_W-1:0] bits);
		@(negedge clk);
		while ($urandom_range(99) < feed_gap_pct) begin
			item_ch.valid <= 1'b0;
			item_ch.kind <= 1'($urandom);
			item_ch.sensor_bits <= SENS_W'($urandom);
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= k;
		item_ch.sensor_bits <= bits;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
	endtask

	task automatic tick(input int n);
		repeat (n) send_item(KIND_TICK, SENS_W'($urandom));
	endtask

	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (motor_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
	endtask

	task automatic set_config(input logic [DATA_W-1:0] pwm, input logic [DATA_W-1:0] side,
		input logic [DATA_W-1:0] uturn, input logic [DATA_W-1:0] white,
		input logic [DATA_W-1:0] junction);
		write_reg(REG_PWM_NOMINAL, pwm);
		write_reg(REG_SIDE_TURN, side);
		write_reg(REG_UTURN, uturn);
		write_reg(REG_WHITE_TIME, white);
		write_reg(REG_JUNCTION, junction);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_reset_values();
		send_item(KIND_SAMPLE, CENTRE_BITS);
		send_item(KIND_SAMPLE, 8'h08);
		send_item(KIND_SAMPLE, 8'h10);
		send_item(KIND_SAMPLE, 8'h42);
		settle();
	endtask

	task automatic test_register_writes();
		for (int i = REG_JUNCTION + 1; i < 2 ** IDX_W; i++)
			write_reg(i[IDX_W-1:0], DATA_W'($urandom));
		set_config(16'hFFFF, 16'd1, 16'd2, 16'd0, 16'd0);
		send_item(KIND_SAMPLE, CENTRE_BITS);
	endtask

	task automatic test_white_uturn();
		send_item(KIND_SAMPLE, 8'h00);
		tick(1);
		send_item(KIND_SAMPLE, 8'h00);
		send_item(KIND_SAMPLE, 8'hFF);
		tick(2);
		send_item(KIND_SAMPLE, 8'h00);
	endtask

	task automatic test_side_turns();
		tick(2);
		send_item(KIND_SAMPLE, 8'hF8);
		tick(1);
		send_item(KIND_SAMPLE, 8'hF8);
		send_item(KIND_SAMPLE, 8'h00);
		tick(1);
		send_item(KIND_SAMPLE, 8'h1F);
		tick(1);
		send_item(KIND_SAMPLE, 8'h1F);
		send_item(KIND_SAMPLE, 8'h3F);
		send_item(KIND_SAMPLE, 8'h1B);
		send_item(KIND_SAMPLE, 8'hE7);
	endtask

	task automatic test_random_traffic();
		int sent;
		int run;
		bit held;
		road_t road;
		logic [SENS_W-1:0] bits;
		for (int c = 0; c < 6; c++) begin
			settle();
			feed_gap_pct = (c < 2) ? 24 : (c < 4) ? 81 : 0;
			drain_stall_pct = (c < 2) ? 81 : (c < 4) ? 24 : 0;
			case (c)
				0: set_config(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
				2: set_config(16'hC000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				default: set_config(DATA_W'($urandom), DATA_W'($urandom_range(0, 30)),
					DATA_W'($urandom_range(0, 40)), DATA_W'($urandom_range(0, 12)),
					DATA_W'($urandom_range(0, 8)));
			endcase
			sent = 0;
			held = 1'b0;
			while (sent < CHUNK_ITEMS) begin
				road = road_t'($urandom_range(ROAD_NOISE));
				run = $urandom_range(1, 10);
				repeat (run) begin
					repeat ($urandom_range(0, 3)) begin
						tick(1);
						sent++;
					end
					case (road)
						ROAD_WHITE:   bits = '0;
						ROAD_CENTRE:  bits = CENTRE_BITS | (SENS_W'($urandom) & 8'b0100_0010);
						ROAD_DRIFT_R: bits = (8'd1 << INNER_RIGHT_BIT)
							| (SENS_W'($urandom) & RIGHT_BITS);
						ROAD_DRIFT_L: bits = (8'd1 << INNER_LEFT_BIT)
							| (SENS_W'($urandom) & LEFT_BITS);
						ROAD_CROSS_L: bits = LEFT_BITS | CENTRE_BITS
							| (SENS_W'($urandom) & RIGHT_BITS);
						ROAD_CROSS_R: bits = RIGHT_BITS | CENTRE_BITS
							| (SENS_W'($urandom) & LEFT_BITS);
						default:      bits = SENS_W'($urandom);
					endcase
					if ($urandom_range(9) == 0)
						bits = SENS_W'($urandom);
					send_item(KIND_SAMPLE, bits);
					sent++;
					if (!held && sent >= CHUNK_ITEMS / 2) begin
						settle();
						held = 1'b1;
					end
				end
			end
		end
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_TICK;
		item_ch.sensor_bits = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_PWM_NOMINAL;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_register_writes();
		test_white_uturn();
		test_side_turns();
		test_random_traffic();
		settle();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
